[rtl/pgf_pkg.sv]
// Package for the processor grid factorizer: shared constants and the sequencer state type.
package pgf_pkg;

  // Widths of the fixed stream fields
  localparam int PROC_W = 16;
  localparam int DIM_W  = 2;
  localparam int PTS_W  = 16;
  localparam int OUT_W  = 16;

  // Grid dimensions held in storage, and the most that may take part
  localparam int          NUM_DIMS = 3;
  localparam int          DIM_IW   = $clog2(NUM_DIMS);
  localparam logic [DIM_W-1:0] MAX_DIMS = 2'd3;

  // Default width of the internal processor count
  localparam int COUNT_BITS_DEF = 16;

  // Packed stream widths, rounded up to whole bytes
  localparam int IN_FIELDS_W = PROC_W + DIM_W + 3 * PTS_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_QMUL,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_APPLY,
    ST_FIN
  } pgf_state_t;

endpackage

[rtl/pgf_div.sv]
// Iterative restoring divider: one quotient bit per cycle.
module pgf_div
  import pgf_pkg::*;
#(
  parameter int CW = COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] quotient,
  output logic [CW-1:0] remainder
);

  localparam int CNT_W = $clog2(CW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    quo_r;
  logic [CW-1:0]    rem_r;
  logic [CW-1:0]    dvs_r;

  logic [CW:0]      shifted;
  logic [CW:0]      diff;
  logic [CW-1:0]    rem_nxt;

  assign shifted = {rem_r, quo_r[CW-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  // keep the trial difference when it did not go negative
  assign rem_nxt = diff[CW] ? shifted[CW-1:0] : diff[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[CW-2:0], ~diff[CW]};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/processor_grid_factorizer_core.sv]
// Top level of the processor grid factorizer: sequencer, shared multiplier and stream ports.
//
// Splits proc_count over one to three grid dimensions. Every dimension starts with one
// processor; while processors remain unused, the greatest prime factor of the remaining
// count is found by trial division (2, then odd divisors up to the square root) and is
// given to the dimension with the most grid points per processor, ratios being compared
// exactly by cross products. Ties go to the dimension with fewer processors when its ratio
// exceeds one. A count of 0 or 1 yields all ones, as do dimensions that take no part.
// One transaction is worked at a time and in_tready is low meanwhile. The run time is
// dominated by the trial division: each candidate divisor goes through the shared
// bit-serial divider (and through ST_QMUL when it divides), and about sqrt(n)/2
// candidates are tried for each prime factor taken out. The slowest 16-bit counts are
// primes and products of two primes near 256. Each factor also passes ST_CMP_A, ST_CMP_B
// and ST_CMP_C per compared dimension, plus ST_CHECK, ST_TEST and ST_APPLY.
// A finished result sits in the output register while the next transaction is accepted.
module processor_grid_factorizer_core
  import pgf_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, from bit 0: proc_count[15:0], dim_count[1:0], points_x[15:0],
  // points_y[15:0], points_z[15:0], zero fill
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata, from bit 0: procs_x[15:0], procs_y[15:0], procs_z[15:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = COUNT_BITS;
  localparam int AW = (CW > PTS_W) ? CW : PTS_W;   // multiplier operand A
  localparam int PW = AW + CW;                     // product
  localparam int SW = CW + 2;                      // running square of the divisor

  // unpack the input transaction
  logic [PROC_W-1:0] in_proc_count;
  logic [DIM_W-1:0]  in_dim_count;
  logic [PTS_W-1:0]  in_points [NUM_DIMS];

  assign in_proc_count = in_tdata[PROC_W-1:0];
  assign in_dim_count  = in_tdata[PROC_W +: DIM_W];
  assign in_points[0]  = in_tdata[PROC_W + DIM_W +: PTS_W];
  assign in_points[1]  = in_tdata[PROC_W + DIM_W + PTS_W +: PTS_W];
  assign in_points[2]  = in_tdata[PROC_W + DIM_W + 2 * PTS_W +: PTS_W];

  pgf_state_t state_r, state_nxt;

  logic [PTS_W-1:0]  pts_r   [NUM_DIMS];
  logic [CW-1:0]     procs_r [NUM_DIMS];
  logic [DIM_W-1:0]  nd_r;
  logic [CW-1:0]     rem_r;     // processors still unused
  logic [CW-1:0]     n_r;       // value being factored
  logic [CW-1:0]     q_r;       // product of factors divided out of n
  logic [CW-1:0]     d_r;       // trial divisor
  logic [SW-1:0]     sq_r;      // d_r squared
  logic [CW-1:0]     factor_r;  // greatest prime factor found
  logic [DIM_IW-1:0] best_r;
  logic [DIM_IW-1:0] idx_r;
  logic [PW-1:0]     lhs_r;
  logic [PW-1:0]     rhs_r;
  logic [PTS_W-1:0]  pts_i_r;
  logic [CW-1:0]     procs_best_r;
  logic              gt_r;
  logic              lt_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [DIM_W-1:0]  nd_sat;
  logic              in_fire;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [CW-1:0]     div_quo;
  logic [CW-1:0]     div_rem;
  logic [DIM_IW-1:0] pts_sel;
  logic [DIM_IW-1:0] procs_sel;
  logic [PTS_W-1:0]  pts_rd;
  logic [CW-1:0]     procs_rd;
  logic [AW-1:0]     mul_a;
  logic [CW-1:0]     mul_b;
  logic [PW-1:0]     mul_p;
  logic              prime_found;
  logic              more_dims;
  logic              take_i;

  // saturate the dimension count into 1..MAX_DIMS
  always_comb begin
    priority if (in_dim_count == '0) begin
      nd_sat = DIM_W'(1);
    end else if (in_dim_count > MAX_DIMS) begin
      nd_sat = MAX_DIMS;
    end else begin
      nd_sat = in_dim_count;
    end
  end

  assign in_fire     = in_tvalid && in_tready;
  assign out_free    = !out_tvalid_r || out_tready;
  assign prime_found = sq_r > SW'(n_r);
  assign more_dims   = (DIM_W'(idx_r) + 1'b1) < nd_r;

  // one read port per register array each cycle
  assign pts_rd   = pts_r[pts_sel];
  assign procs_rd = procs_r[procs_sel];

  // shared multiplier, registered at its destination
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // replace the best dimension on a larger ratio, or on an equal ratio above one
  // when the candidate holds fewer processors
  assign take_i = (lhs_r > rhs_r) || ((lhs_r == rhs_r) && gt_r && lt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = (rem_r > CW'(1)) ? ST_TEST : ST_FIN;
      ST_TEST: begin
        if (prime_found) begin
          state_nxt = (nd_r > DIM_W'(1)) ? ST_CMP_A : ST_APPLY;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = (div_rem == '0) ? ST_QMUL : ST_TEST;
        end
      end
      ST_QMUL:  state_nxt = ST_TEST;
      ST_CMP_A: state_nxt = ST_CMP_B;
      ST_CMP_B: state_nxt = ST_CMP_C;
      ST_CMP_C: state_nxt = more_dims ? ST_CMP_A : ST_APPLY;
      ST_APPLY: state_nxt = ST_CHECK;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: handshake, divider launch, read selects and multiplier operands
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    pts_sel   = best_r;
    procs_sel = best_r;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_TEST: div_start = !prime_found;
      ST_QMUL: begin
        mul_a = AW'(q_r);
        mul_b = d_r;
      end
      ST_CMP_A: begin
        pts_sel = idx_r;
        mul_a   = AW'(pts_rd);
        mul_b   = procs_rd;
      end
      ST_CMP_B: begin
        procs_sel = idx_r;
        mul_a     = AW'(pts_rd);
        mul_b     = procs_rd;
      end
      ST_APPLY: begin
        mul_a = AW'(procs_rd);
        mul_b = factor_r;
      end
      default: begin
      end
    endcase
  end

  pgf_div #(
    .CW(CW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (d_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          for (int k = 0; k < NUM_DIMS; k++) begin
            pts_r[k]   <= in_points[k];
            procs_r[k] <= CW'(1);
          end
          nd_r  <= nd_sat;
          rem_r <= CW'(in_proc_count);
        end
      end
      ST_CHECK: begin
        // start a fresh factor search on the unused processors
        n_r  <= rem_r;
        q_r  <= CW'(1);
        d_r  <= CW'(2);
        sq_r <= SW'(4);
      end
      ST_TEST: begin
        if (prime_found) begin
          factor_r <= n_r;
          best_r   <= '0;
          idx_r    <= DIM_IW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            n_r <= div_quo;
          end else if (d_r == CW'(2)) begin
            d_r  <= CW'(3);
            sq_r <= SW'(9);
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_r  <= d_r + CW'(2);
            sq_r <= sq_r + {d_r, 2'b00} + SW'(4);
          end
        end
      end
      ST_QMUL: q_r <= CW'(mul_p);
      ST_CMP_A: begin
        lhs_r        <= mul_p;
        pts_i_r      <= pts_rd;
        procs_best_r <= procs_rd;
      end
      ST_CMP_B: begin
        rhs_r <= mul_p;
        gt_r  <= AW'(pts_i_r) > AW'(procs_rd);
        lt_r  <= procs_rd < procs_best_r;
      end
      ST_CMP_C: begin
        if (take_i) best_r <= idx_r;
        idx_r <= idx_r + 1'b1;
      end
      ST_APPLY: begin
        procs_r[best_r] <= CW'(mul_p);
        rem_r           <= q_r;
      end
      ST_FIN: begin
        if (out_free) begin
          out_tdata_r <= OUT_DATA_W'({OUT_W'(procs_r[2]), OUT_W'(procs_r[1]),
                                      OUT_W'(procs_r[0])});
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // a transaction is never accepted while one is being worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CHECK)
    else $error("sequencer did not leave idle after accepting a transaction");

  // the divider is only launched with a real trial divisor
  a_div_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> d_r >= CW'(2))
    else $error("divider launched with a divisor below two");

  // the divider reports completion only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider completion outside the wait state");

  // only a real factor is applied, to a dimension that takes part
  a_apply_factor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_APPLY |-> (factor_r >= CW'(2)) && (DIM_W'(best_r) < nd_r))
    else $error("bad factor or dimension applied");

  // a finished result is only overwritten once the previous one was taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |=> state_r != ST_IDLE || $past(state_r) != ST_FIN
      || $stable(out_tdata_r))
    else $error("pending result overwritten");

endmodule

[bench/processor_grid_factorizer_checker.sv]
// Checker for the processor grid factorizer: watches both streams, predicts and compares splits.
`timescale 1ns / 1ps

module processor_grid_factorizer_checker
  import pgf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    error_count,
  output int                    splits_pending,
  output int                    splits_checked
);

  // Packed so that procs_x sits in the lowest bits, as on out_tdata
  typedef struct packed {
    logic [OUT_W-1:0] procs_z;
    logic [OUT_W-1:0] procs_y;
    logic [OUT_W-1:0] procs_x;
  } grid_split_t;

  grid_split_t expected_splits[$];

  function automatic logic [31:0] least_divisor(input logic [31:0] n);
    logic [31:0] d;
    if (n < 2) return n;
    if (!n[0]) return 32'd2;
    for (d = 32'd3; d * d <= n; d += 32'd2) begin
      if (n % d == 0) return d;
    end
    return n;
  endfunction

  function automatic logic [31:0] greatest_prime(input logic [31:0] n);
    logic [31:0] f;
    f = least_divisor(n);
    while (f != n && f >= 2) begin
      n = n / f;
      f = least_divisor(n);
    end
    return n;
  endfunction

  function automatic grid_split_t split_processors(input logic [PROC_W-1:0] total,
                                                   input logic [DIM_W-1:0]  dims,
                                                   input logic [PTS_W-1:0]  px,
                                                   input logic [PTS_W-1:0]  py,
                                                   input logic [PTS_W-1:0]  pz);
    logic [63:0] pts [3];
    logic [63:0] procs [3];
    logic [63:0] used;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [31:0] factor;
    int          active;
    int          best;
    grid_split_t split;
    pts[0] = 64'(px);
    pts[1] = 64'(py);
    pts[2] = 64'(pz);
    for (int k = 0; k < 3; k++) procs[k] = 64'(1);
    used   = 64'(1);
    active = int'(dims);
    if (active == 0) active = 1;
    if (active > int'(MAX_DIMS)) active = int'(MAX_DIMS);
    while (used < 64'(total)) begin
      best = 0;
      for (int k = 1; k < active; k++) begin
        lhs = pts[k] * procs[best];
        rhs = pts[best] * procs[k];
        // on a tie, prefer the less loaded dimension if its ratio exceeds one
        if (lhs > rhs || (lhs == rhs && pts[k] > procs[k] && procs[k] < procs[best]))
          best = k;
      end
      factor = greatest_prime(32'(64'(total) / used));
      if (factor < 2) break;
      procs[best] = procs[best] * 64'(factor);
      used        = used * 64'(factor);
    end
    split.procs_x = procs[0][OUT_W-1:0];
    split.procs_y = procs[1][OUT_W-1:0];
    split.procs_z = procs[2][OUT_W-1:0];
    return split;
  endfunction

  always @(posedge clk) begin
    grid_split_t want;
    grid_split_t got;
    if (!rst_n) begin
      expected_splits.delete();
      error_count    <= 0;
      splits_pending <= 0;
      splits_checked <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_splits.insert(expected_splits.size(),
                               split_processors(in_tdata[15:0], in_tdata[17:16],
                                                in_tdata[33:18], in_tdata[49:34],
                                                in_tdata[65:50]));
      if (out_tvalid && out_tready) begin
        got = out_tdata[3*OUT_W-1:0];
        if (expected_splits.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, got x=%0d y=%0d z=%0d",
                   $time, got.procs_x, got.procs_y, got.procs_z);
          error_count <= error_count + 1;
        end else begin
          want = expected_splits.pop_front();
          if (got.procs_x !== want.procs_x)
            $display("%0t: procs_x mismatch: expected %0d, got %0d",
                     $time, want.procs_x, got.procs_x);
          if (got.procs_y !== want.procs_y)
            $display("%0t: procs_y mismatch: expected %0d, got %0d",
                     $time, want.procs_y, got.procs_y);
          if (got.procs_z !== want.procs_z)
            $display("%0t: procs_z mismatch: expected %0d, got %0d",
                     $time, want.procs_z, got.procs_z);
          if (got !== want) error_count <= error_count + 1;
          splits_checked <= splits_checked + 1;
        end
      end
      splits_pending <= expected_splits.size();
    end
  end

endmodule

[bench/processor_grid_factorizer_core_test.sv]
// Top of the processor grid factorizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module processor_grid_factorizer_core_test
  import pgf_pkg::*;
();

  // Most random items finish far sooner than the slowest ones.
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int HOLD_CYCLES  = 4000;
  localparam int DRAIN_CYCLES = 200;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;

  int error_count;
  int splits_pending;
  int splits_checked;
  int requests_sent = 0;
  int cycle_count   = 0;

  // Idle percentages for each side; changed between phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // One-shot request for a long output stall, serviced by the receiver process
  logic hold_go    = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  processor_grid_factorizer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  processor_grid_factorizer_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .error_count    (error_count),
    .splits_pending (splits_pending),
    .splits_checked (splits_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, splits_pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random backpressure, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offer one request transaction; called right after a rising edge.
  // Drop valid only on an idle gap, so back-to-back requests keep it high.
  task automatic offer_request(input logic [PROC_W-1:0] proc_count,
                               input logic [DIM_W-1:0]  dim_count,
                               input logic [PTS_W-1:0]  points_x,
                               input logic [PTS_W-1:0]  points_y,
                               input logic [PTS_W-1:0]  points_z);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}},
                  points_z, points_y, points_x, dim_count, proc_count};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // Hold the sender until every predicted split has come back.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (splits_pending != 0) @(posedge clk);
  endtask

  // Random request: mostly modest counts so the trial division stays short,
  // with a share of full-range counts, zero points and out-of-range dimension counts.
  task automatic offer_random_request();
    logic [PROC_W-1:0] count;
    logic [DIM_W-1:0]  dims;
    logic [PTS_W-1:0]  pts [3];
    int                pick;
    pick = $urandom_range(99);
    if (pick < 60)      count = PROC_W'($urandom_range(1023, 2));
    else if (pick < 85) count = PROC_W'($urandom_range(65535));
    else if (pick < 92) count = PROC_W'(1) << $urandom_range(15);
    else                count = PROC_W'($urandom_range(1));
    dims = ($urandom_range(9) == 0) ? 2'd0 : DIM_W'($urandom_range(3, 1));
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(99);
      if (pick < 10)      pts[k] = '0;
      else if (pick < 50) pts[k] = PTS_W'($urandom_range(64, 1));
      else                pts[k] = PTS_W'($urandom_range(65535, 1));
    end
    offer_request(count, dims, pts[0], pts[1], pts[2]);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, tie rules, degenerate dimension and point values
    offer_request(16'd0,     2'd3, 16'd100,   16'd100,   16'd100);   // count of zero
    offer_request(16'd1,     2'd3, 16'd100,   16'd100,   16'd100);   // count of one
    offer_request(16'd65535, 2'd3, 16'd65535, 16'd65535, 16'd65535);
    offer_request(16'd65521, 2'd2, 16'd300,   16'd200,   16'd9);     // largest 16-bit prime
    offer_request(16'd32768, 2'd3, 16'd1000,  16'd1000,  16'd1000);  // long run of twos
    offer_request(16'd12,    2'd0, 16'd5,     16'd50,    16'd500);   // zero dims acts as one
    offer_request(16'd12,    2'd1, 16'd5,     16'd50,    16'd500);
    offer_request(16'd60,    2'd2, 16'd0,     16'd0,     16'd7);     // all active points zero
    offer_request(16'd60,    2'd3, 16'd0,     16'd0,     16'd0);
    offer_request(16'd64,    2'd3, 16'd0,     16'd0,     16'd65535);
    offer_request(16'd8,     2'd2, 16'd20,    16'd10,    16'd1);     // tie won by lighter dim
    offer_request(16'd64,    2'd2, 16'd2,     16'd1,     16'd1);     // tie at ratio one stays
    offer_request(16'd30030, 2'd3, 16'd1200,  16'd700,   16'd90);
    offer_request(16'd65498, 2'd3, 16'd4000,  16'd4000,  16'd4000);  // two times a big prime
    offer_request(16'd65535, 2'd1, 16'd1,     16'd2,     16'd3);
    offer_request(16'd1024,  2'd3, 16'd1,     16'd65535, 16'd1);
    offer_request(16'd2,     2'd2, 16'hAAAA,  16'h5555,  16'hFFFF);
    offer_request(16'hFFFF,  2'd2, 16'h5555,  16'hAAAA,  16'hFFFF);
    offer_request(16'd49,    2'd3, 16'd7,     16'd7,     16'd7);
    offer_request(16'd3,     2'd3, 16'd65535, 16'd65535, 16'd65535);
    offer_request(16'd46410, 2'd3, 16'd8,     16'd65535, 16'd256);

    // Random phase one: sender idles lightly, receiver heavily
    tx_idle_pct <= 30;
    rx_idle_pct <= 60;
    repeat (27) offer_random_request();

    // Random phase two: the other way round, then let everything drain
    tx_idle_pct <= 60;
    rx_idle_pct <= 30;
    repeat (26) offer_random_request();
    wait_for_drain();

    // Random phase three: no idling, but open with a long output stall so the
    // block fills up and backs up its input
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_go     <= 1'b1;
    repeat (26) offer_random_request();
    in_tvalid <= 1'b0;

    // Wait for the last split, then watch a little longer for stray results
    @(posedge clk);
    while (splits_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (directed extremes, tie rules, zero points, zero and",
             requests_sent);
    $display("  full dimension counts, mixed idling, long output stall); %0d splits compared",
             splits_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
